// ===== hw/rtl/ordered_list_engine_defines.svh =====
// Assertion macros for the list engine back end
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle
`define OLE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the following cycle
`define OLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ole_pkg.sv =====
package ole_pkg;

  localparam int DefCapacity = 64;
  localparam int ValW = 32;
  localparam int IdxW = 8;
  localparam int LenW = 7;
  localparam int PosW = 7;

  typedef enum logic [3:0] {
    M_PUSH_BACK  = 4'd0,
    M_PUSH_FRONT = 4'd1,
    M_INSERT_AT  = 4'd2,
    M_POP_BACK   = 4'd3,
    M_POP_FRONT  = 4'd4,
    M_REMOVE_AT  = 4'd5,
    M_CONTAINS   = 4'd6,
    M_GET_AT     = 4'd7,
    M_INDEX_OF   = 4'd8,
    M_LENGTH     = 4'd9,
    M_CLEAR      = 4'd10
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_READ,
    OP_SEARCH,
    OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DOWN,
    S_READ,
    S_SEARCH,
    S_DONE
  } bstate_t;
endpackage

// ===== hw/rtl/ole_front.sv =====
// Classifies a request against the current length and queues it for the back end.
module ole_front import ole_pkg::*; #(
  parameter int CntW = 7
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [3:0]      mode,
  input  logic [ValW-1:0] item_value,
  input  logic [PosW-1:0] position,
  input  logic [CntW-1:0] count,
  input  logic [CntW-1:0] capacity,
  input  logic            back_busy,
  input  logic            take,
  output logic            busy,
  output logic            q_valid,
  output op_t             q_op,
  output logic            q_index_mode,
  output status_t         q_status,
  output logic [CntW-1:0] q_slot,
  output logic [ValW-1:0] q_value
);

  // Wide enough for both the position and the count plus one
  localparam int PeW = ((CntW > PosW) ? CntW : PosW) + 1;

  // One-entry queue between classify and execute
  logic            pend;
  op_t             op_c;
  status_t         st_c;
  logic [CntW-1:0] slot_c;
  logic [PeW-1:0]  pos_e;

  assign busy = pend | back_busy;
  assign pos_e = PeW'(position);

  // Classify the request
  always_comb begin
    op_c = OP_NONE;
    st_c = ST_OK;
    slot_c = '0;
    case (mode)
      M_PUSH_BACK, M_PUSH_FRONT, M_INSERT_AT: begin
        if (mode == M_PUSH_BACK) slot_c = count;
        else if (mode == M_PUSH_FRONT) slot_c = '0;
        else slot_c = CntW'(pos_e - 1'b1);
        if (mode == M_INSERT_AT && (pos_e == '0 || pos_e > PeW'(count) + 1'b1))
          st_c = ST_RANGE;
        else if (count >= capacity) st_c = ST_FULL;
        else op_c = OP_INSERT;
      end
      M_POP_BACK, M_POP_FRONT, M_REMOVE_AT, M_GET_AT: begin
        if (mode == M_POP_BACK) slot_c = count - 1'b1;
        else if (mode == M_POP_FRONT) slot_c = '0;
        else slot_c = CntW'(pos_e - 1'b1);
        if (count == '0) st_c = ST_EMPTY;
        else if ((mode == M_REMOVE_AT || mode == M_GET_AT) &&
                 (pos_e == '0 || pos_e > PeW'(count)))
          st_c = ST_RANGE;
        else op_c = (mode == M_GET_AT) ? OP_READ : OP_REMOVE;
      end
      M_CONTAINS, M_INDEX_OF: op_c = OP_SEARCH;
      M_CLEAR: op_c = OP_CLEAR;
      default: op_c = OP_NONE;
    endcase
  end

  // Hold the queued request until the back end takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (start && !busy) begin
      pend <= 1'b1;
    end else if (take) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      q_op <= op_c;
      q_status <= st_c;
      q_slot <= slot_c;
      q_value <= item_value;
      q_index_mode <= (mode == M_INDEX_OF);
    end
  end

  assign q_valid = pend;
endmodule

// ===== hw/rtl/ole_back.sv =====
// Executes queued requests on the entry memory one entry per cycle.
module ole_back import ole_pkg::*; #(
  parameter int Capacity = DefCapacity,
  parameter int CntW = 7
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  op_t             q_op,
  input  logic            q_index_mode,
  input  status_t         q_status,
  input  logic [CntW-1:0] q_slot,
  input  logic [ValW-1:0] q_value,
  output logic            take,
  output logic            back_busy,
  output logic [CntW-1:0] count,
  output logic            done,
  output logic [ValW-1:0] result_value,
  output logic [IdxW-1:0] result_index,
  output logic            found,
  output logic [LenW-1:0] list_size,
  output logic [2:0]      status
);
  `include "ordered_list_engine_defines.svh"

  localparam int AW = $clog2(Capacity);

  logic [ValW-1:0] mem [Capacity];
  logic [ValW-1:0] rdata;
  bstate_t state, state_next;
  op_t             op;
  logic            idx_mode;
  status_t         st;
  logic [CntW-1:0] slot, ptr;
  logic [ValW-1:0] val;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [ValW-1:0] wr_data;
  logic            hit;

  assign take = (state == S_IDLE) && q_valid;
  assign back_busy = (state != S_IDLE);
  assign hit = (rdata == val);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_status != ST_OK) state_next = S_DONE;
          else if (q_op == OP_INSERT)
            state_next = (q_slot == count) ? S_DONE : S_SHIFT_UP;
          else if (q_op == OP_REMOVE || q_op == OP_READ) state_next = S_READ;
          else if (q_op == OP_SEARCH)
            state_next = (count == '0) ? S_DONE : S_SEARCH;
          else state_next = S_DONE;
        end
      end
      S_SHIFT_UP: if (ptr == slot) state_next = S_DONE;
      S_READ: state_next = (op == OP_REMOVE && slot + 1'b1 < count) ? S_SHIFT_DOWN : S_DONE;
      S_SHIFT_DOWN: if (ptr + 1'b1 >= count) state_next = S_DONE;
      S_SEARCH: if (hit || ptr + 1'b1 >= count) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    rd_en = 1'b0;
    rd_addr = AW'(ptr);
    wr_en = 1'b0;
    wr_addr = AW'(ptr);
    wr_data = rdata;
    case (state)
      S_IDLE: begin
        rd_en = q_valid;
        if (q_op == OP_INSERT) rd_addr = AW'(count - 1'b1);
        else rd_addr = AW'(q_slot);
        if (q_valid && q_status == ST_OK && q_op == OP_INSERT && q_slot == count) begin
          wr_en = 1'b1;
          wr_addr = AW'(q_slot);
          wr_data = q_value;
        end
      end
      S_SHIFT_UP: begin
        rd_en = 1'b1;
        rd_addr = AW'(ptr - 1'b1 - 1'b1);
        wr_en = 1'b1;
        wr_addr = AW'(ptr);
        wr_data = (ptr == slot) ? val : rdata;
        if (ptr != slot) begin
          wr_addr = AW'(ptr);
        end
      end
      S_READ: begin
        rd_en = 1'b1;
        rd_addr = AW'(slot + 1'b1);
      end
      S_SHIFT_DOWN: begin
        rd_en = 1'b1;
        rd_addr = AW'(ptr + 1'b1 + 1'b1);
        wr_en = 1'b1;
        wr_addr = AW'(ptr);
      end
      S_SEARCH: begin
        rd_en = 1'b1;
        rd_addr = AW'(ptr + 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Working registers and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (state)
        S_IDLE: if (q_valid && q_status == ST_OK) begin
          if (q_op == OP_CLEAR) count <= '0;
          else if (q_op == OP_INSERT && q_slot == count) count <= count + 1'b1;
        end
        S_SHIFT_UP: if (ptr == slot) count <= count + 1'b1;
        S_READ: if (op == OP_REMOVE && state_next == S_DONE) count <= count - 1'b1;
        S_SHIFT_DOWN: if (state_next == S_DONE) count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op <= q_op;
        idx_mode <= q_index_mode;
        st <= (q_op == OP_SEARCH && count == '0 && q_status == ST_OK) ?
              ST_NOTFOUND : q_status;
        slot <= q_slot;
        val <= q_value;
        ptr <= (q_op == OP_INSERT) ? count : ((q_op == OP_SEARCH) ? '0 : q_slot);
        found <= 1'b0;
      end
      S_SHIFT_UP: ptr <= ptr - 1'b1;
      S_READ: val <= rdata;
      S_SHIFT_DOWN: ptr <= ptr + 1'b1;
      S_SEARCH: begin
        if (hit) found <= 1'b1;
        else begin
          ptr <= ptr + 1'b1;
          if (ptr + 1'b1 >= count) st <= ST_NOTFOUND;
        end
      end
      default: ;
    endcase
  end

  // Output strobe and fields
  always_comb begin
    done = (state == S_DONE);
    list_size = LenW'(count);
    status = st;
    result_value = '0;
    result_index = '0;
    if (st != ST_OK) result_value = '1;
    else if (op == OP_REMOVE || op == OP_READ) result_value = val;
    if (op == OP_SEARCH && idx_mode) begin
      if (found) result_index = IdxW'(ptr + 1'b1);
      else result_index = '1;
    end
  end

  `OLE_ASSERT_NEXT(a_take_leaves_idle, clk, rst, take, state != S_IDLE, "take stayed idle")
  `OLE_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CntW'(Capacity), "count over capacity")
  `OLE_ASSERT_NEXT(a_done_one, clk, rst, done, !done, "result strobe held")
endmodule

// ===== hw/rtl/ordered_list_engine.sv =====
// Appends, errors, length and clear go from idle straight to the result state; inserts,
// removals and searches walk the entry memory one entry per cycle, with at most one
// read and one write a cycle. One item in flight at a time; the next item is accepted
// only once the back end is idle again after the result strobe.
// The result is strobed on done for one cycle; the receiver cannot stall.
// Reset empties the list; entry contents are left undefined.
module ordered_list_engine import ole_pkg::*; #(
  parameter int CAPACITY = DefCapacity
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [3:0]      mode,
  input  logic [ValW-1:0] item_value,
  input  logic [PosW-1:0] position,
  output logic            done,
  output logic [ValW-1:0] result_value,
  output logic [IdxW-1:0] result_index,
  output logic            found,
  output logic [LenW-1:0] list_size,
  output logic [2:0]      status
);
  localparam int CntW = $clog2(CAPACITY + 1) + 1;

  logic            back_busy, take, q_valid, q_index_mode;
  op_t             q_op;
  status_t         q_status;
  logic [CntW-1:0] q_slot, count;
  logic [ValW-1:0] q_value;

  ole_front #(.CntW(CntW)) u_front (
    .clk, .rst, .start, .mode, .item_value, .position, .count,
    .capacity(CntW'(CAPACITY)), .back_busy, .take, .busy,
    .q_valid, .q_op, .q_index_mode, .q_status, .q_slot, .q_value
  );

  ole_back #(.Capacity(CAPACITY), .CntW(CntW)) u_back (
    .clk, .rst, .q_valid, .q_op, .q_index_mode, .q_status, .q_slot, .q_value,
    .take, .back_busy, .count, .done, .result_value, .result_index, .found,
    .list_size, .status
  );
endmodule

// ===== tb/tb_ordered_list_engine.sv =====
`timescale 1ns / 1ps

module tb_ordered_list_engine;
  import ole_pkg::*;

  localparam int Cap = DefCapacity;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  index;
    logic        hit;
    logic [6:0]  len;
    logic [2:0]  st;
  } answer_t;

  typedef struct {
    logic [3:0]  md;
    logic [31:0] val;
    logic [6:0]  pos;
    bit          typed;
    answer_t     ans;
  } row_t;

  logic clk;
  logic rst;
  logic start;
  logic [3:0] mode;
  logic [31:0] item_value;
  logic [6:0] position;
  logic busy;
  logic done;
  logic [31:0] result_value;
  logic [7:0] result_index;
  logic found;
  logic [6:0] list_size;
  logic [2:0] status;

  ordered_list_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .item_value(item_value), .position(position), .done(done),
    .result_value(result_value), .result_index(result_index), .found(found),
    .list_size(list_size), .status(status)
  );

  // Shadow copy of the list
  logic [31:0] shadow_list[$];
  answer_t pending_answers[$];
  int errors;
  int answers_seen;
  bit quiet;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Compute the answer for one request and update the shadow list
  function automatic answer_t list_answer(logic [3:0] md, logic [31:0] val,
                                          logic [6:0] pos_in);
    answer_t a;
    int n;
    int p;
    int k;
    n = shadow_list.size();
    p = int'(pos_in);
    a = '0;
    a.st = ST_OK;
    case (md)
      M_PUSH_BACK, M_PUSH_FRONT, M_INSERT_AT: begin
        if (md == M_PUSH_BACK) p = n + 1;
        else if (md == M_PUSH_FRONT) p = 1;
        if (p < 1 || p > n + 1) a.st = ST_RANGE;
        else if (n >= Cap) a.st = ST_FULL;
        else shadow_list.insert(p - 1, val);
      end
      M_POP_BACK, M_POP_FRONT, M_REMOVE_AT, M_GET_AT: begin
        if (md == M_POP_BACK) p = n;
        else if (md == M_POP_FRONT) p = 1;
        if (n == 0) a.st = ST_EMPTY;
        else if (p < 1 || p > n) a.st = ST_RANGE;
        else begin
          a.value = shadow_list[p - 1];
          if (md != M_GET_AT) shadow_list.delete(p - 1);
        end
      end
      M_CONTAINS, M_INDEX_OF: begin
        k = 0;
        for (int i = 0; i < n; i++)
          if (k == 0 && shadow_list[i] == val) k = i + 1;
        if (k != 0) begin
          a.hit = 1'b1;
          if (md == M_INDEX_OF) a.index = k[7:0];
        end else begin
          a.st = ST_NOTFOUND;
          if (md == M_INDEX_OF) a.index = 8'hFF;
        end
      end
      M_CLEAR: shadow_list.delete();
      default: ;
    endcase
    if (a.st != ST_OK) a.value = 32'hFFFF_FFFF;
    a.len = 7'(shadow_list.size());
    return a;
  endfunction

  // Issue one item, with an optional gap before it
  task automatic send_item(logic [3:0] md, logic [31:0] val, logic [6:0] pos,
                           bit typed, answer_t typed_ans);
    answer_t a;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    mode <= md;
    item_value <= val;
    position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    a = list_answer(md, val, pos);
    pending_answers.push_back(typed ? typed_ans : a);
  endtask

  // Check each strobed result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      answer_t e;
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = pending_answers.pop_front();
        if (result_value !== e.value) begin
          $error("result_value exp %h got %h", e.value, result_value); errors++;
        end
        if (result_index !== e.index) begin
          $error("result_index exp %h got %h", e.index, result_index); errors++;
        end
        if (found !== e.hit) begin
          $error("found exp %b got %b", e.hit, found); errors++;
        end
        if (list_size !== e.len) begin
          $error("list_size exp %0d got %0d", e.len, list_size); errors++;
        end
        if (status !== e.st) begin
          $error("status exp %0d got %0d", e.st, status); errors++;
        end
      end
    end
  end

  function automatic answer_t mk(logic [31:0] v, logic [7:0] ix, logic h,
                                 logic [6:0] l, logic [2:0] s);
    answer_t a;
    a.value = v; a.index = ix; a.hit = h; a.len = l; a.st = s;
    return a;
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5 && shadow_list.size() > 0)
      return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    if (r == 5) return 32'h8000_0000;
    if (r == 6) return 32'h7FFF_FFFF;
    if (r == 7) return $urandom_range(0, 7);
    return $urandom;
  endfunction

  initial begin
    row_t rows[$];
    answer_t none;
    logic [3:0] md;
    logic [6:0] pos;
    int n;
    int sel;
    int fill_target;
    none = '0;
    errors = 0;
    answers_seen = 0;
    quiet = 0;
    rst = 1'b1;
    start = 1'b0;
    mode = '0;
    item_value = '0;
    position = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: empty-list errors, extremes, every mode
    rows.push_back('{M_POP_BACK, 0, 0, 1, mk(-1, 0, 0, 0, ST_EMPTY)});
    rows.push_back('{M_POP_FRONT, 0, 0, 1, mk(-1, 0, 0, 0, ST_EMPTY)});
    rows.push_back('{M_REMOVE_AT, 0, 127, 1, mk(-1, 0, 0, 0, ST_EMPTY)});
    rows.push_back('{M_GET_AT, 0, 1, 1, mk(-1, 0, 0, 0, ST_EMPTY)});
    rows.push_back('{M_INDEX_OF, 5, 0, 1, mk(-1, 8'hFF, 0, 0, ST_NOTFOUND)});
    rows.push_back('{M_CONTAINS, 5, 0, 1, mk(-1, 0, 0, 0, ST_NOTFOUND)});
    rows.push_back('{M_INSERT_AT, 9, 0, 1, mk(-1, 0, 0, 0, ST_RANGE)});
    rows.push_back('{M_INSERT_AT, 9, 2, 1, mk(-1, 0, 0, 0, ST_RANGE)});
    rows.push_back('{M_PUSH_BACK, 32'h7FFF_FFFF, 0, 1, mk(0, 0, 0, 1, ST_OK)});
    rows.push_back('{M_PUSH_FRONT, 32'h8000_0000, 0, 1, mk(0, 0, 0, 2, ST_OK)});
    rows.push_back('{M_INSERT_AT, 32'hFFFF_FFFF, 2, 0, none});
    rows.push_back('{M_INSERT_AT, 0, 4, 0, none});
    rows.push_back('{M_GET_AT, 0, 0, 1, mk(-1, 0, 0, 4, ST_RANGE)});
    rows.push_back('{M_GET_AT, 0, 5, 1, mk(-1, 0, 0, 4, ST_RANGE)});
    rows.push_back('{M_REMOVE_AT, 0, 127, 1, mk(-1, 0, 0, 4, ST_RANGE)});
    rows.push_back('{M_GET_AT, 0, 1, 1, mk(32'h8000_0000, 0, 0, 4, ST_OK)});
    rows.push_back('{M_INDEX_OF, 32'hFFFF_FFFF, 0, 0, none});
    rows.push_back('{M_CONTAINS, 32'h7FFF_FFFF, 0, 0, none});
    rows.push_back('{M_LENGTH, 0, 0, 1, mk(0, 0, 0, 4, ST_OK)});
    rows.push_back('{4'd15, 32'hFFFF_FFFF, 7'h7F, 1, mk(0, 0, 0, 4, ST_OK)});
    rows.push_back('{4'd11, 0, 0, 1, mk(0, 0, 0, 4, ST_OK)});
    rows.push_back('{M_REMOVE_AT, 0, 2, 0, none});
    rows.push_back('{M_POP_BACK, 0, 0, 0, none});
    rows.push_back('{M_POP_FRONT, 0, 0, 0, none});
    rows.push_back('{M_CLEAR, 0, 0, 1, mk(0, 0, 0, 0, ST_OK)});
    foreach (rows[i]) send_item(rows[i].md, rows[i].val, rows[i].pos,
                                rows[i].typed, rows[i].ans);

    // Fill to capacity and push past it, with a search at the far end
    for (int i = 0; i < Cap; i++) send_item(M_PUSH_BACK, i, 0, 0, none);
    send_item(M_PUSH_FRONT, 1, 0, 1, mk(-1, 0, 0, 7'(Cap), ST_FULL));
    send_item(M_PUSH_BACK, 1, 0, 1, mk(-1, 0, 0, 7'(Cap), ST_FULL));
    send_item(M_INSERT_AT, 1, 7'(Cap + 1), 1, mk(-1, 0, 0, 7'(Cap), ST_FULL));
    send_item(M_INSERT_AT, 1, 7'(Cap + 2), 1, mk(-1, 0, 0, 7'(Cap), ST_RANGE));
    send_item(M_INDEX_OF, 32'(Cap - 1), 0, 0, none);
    send_item(M_REMOVE_AT, 0, 7'(Cap), 0, none);
    send_item(M_REMOVE_AT, 0, 1, 0, none);
    send_item(M_CLEAR, 0, 0, 0, none);

    // Random part: wander the fill level up and down with mostly valid positions
    fill_target = 8;
    for (int i = 0; i < 1700; i++) begin
      if (i % 200 == 0) fill_target = $urandom_range(0, Cap);
      if (i == 1500) quiet = 1;
      n = shadow_list.size();
      sel = $urandom_range(0, 99);
      if (sel < 1) md = M_CLEAR;
      else if (sel < 3) md = 4'($urandom_range(11, 15));
      else if (sel < 50) md = (n < fill_target) ? 4'($urandom_range(0, 2))
                                                : 4'($urandom_range(3, 5));
      else md = 4'($urandom_range(0, 9));
      if ($urandom_range(0, 9) == 0) pos = 7'($urandom);
      else if (md == M_INSERT_AT) pos = 7'($urandom_range(1, n + 1));
      else pos = 7'($urandom_range(n == 0 ? 0 : 1, n == 0 ? 3 : n));
      send_item(md, pick_value(), pos, 0, none);
    end
    start <= 1'b0;

    // Drain the outstanding result, then allow the tail latency
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (Cap + 10) @(posedge clk);
    $display("Covered all modes, empty and full lists, range errors and searches;");
    $display("%0d results checked.", answers_seen);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
